FILE: rtl/lookup2_byte_stream_hash_unit_macros.svh
// Assertion macros for the lookup2 byte stream hash unit.
// Included by the RTL files that carry checks; depends on nothing.
`ifndef LOOKUP2_BYTE_STREAM_HASH_UNIT_MACROS_SVH
`define LOOKUP2_BYTE_STREAM_HASH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, ck, rstn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (cond)) \
        else $error("invariant violated");
`define CHK_IMPLY(lbl, ck, rstn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |-> (post)) \
        else $error("implication violated");
`else
`define CHK_ALWAYS(lbl, ck, rstn, cond)
`define CHK_IMPLY(lbl, ck, rstn, pre, post)
`endif
`endif

FILE: rtl/lbsh_pkg.sv
// Shared types and constants of the lookup2 byte stream hash unit.
// No dependencies.
package lbsh_pkg;

    localparam logic [31:0] GOLDEN_WORD   = 32'h9E3779B9;
    localparam int          BLOCK_BYTES   = 12;
    localparam logic [31:0] MAX_NORM_BYTES = 32'd1023;
    localparam int          CFG_INDEX_W   = 1;
    localparam int          JOB_FIFO_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SEED      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMALIZE = 1'b1;

    typedef struct packed {
        logic                         has_block;
        logic                         has_final;
        logic [BLOCK_BYTES-1:0][7:0]  data;
        logic [3:0]                   fill;
        logic [31:0]                  len;
        logic [31:0]                  seed;
    } job_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } mix_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_FIN
    } bk_state_t;

endpackage

FILE: rtl/lookup2_byte_stream_hash_unit.sv
// Top level of the lookup2 byte stream hash unit: front end, job queue, mix engine.
// Depends on lbsh_pkg, lbsh_front, lbsh_queue, lbsh_back.
//
//   channel   direction  handshake        payload
//   input     in         push / full      data_byte, holds_byte, last
//   result    out        empty / pop      hash_value
//   config    in         cfg_wr_en        cfg_index, cfg_data
//
// One byte word per cycle is taken while the job queue has room.
// Each full 12-byte block costs the mix engine an add and 9 mix steps, so long
// messages stream at one byte per cycle while the job queue has room.
// A message end costs an add and 9 mix steps, plus BK_FIN and 9 more when it
// closes a full block; short back-to-back messages are limited by the mix engine.
// Reset clears control state and loads seed 0, normalize on.
module lookup2_byte_stream_hash_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lbsh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic                              holds_byte,
    input  logic                              last,
    output logic                              empty,
    input  logic                              pop,
    output logic [31:0]                       hash_value
);
    import lbsh_pkg::*;

    job_t fr_job;
    job_t head_job;
    logic fr_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    lbsh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .holds_byte (holds_byte),
        .last       (last),
        .job_push   (fr_push),
        .job        (fr_job),
        .q_full     (q_full)
    );

    lbsh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fr_push),
        .wr_job  (fr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty)
    );

    lbsh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head_job),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

endmodule

FILE: rtl/lbsh_front.sv
// Front end: config registers, byte normalize, block packing, job issue.
// Depends on lbsh_pkg.
`include "lookup2_byte_stream_hash_unit_macros.svh"
module lbsh_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lbsh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         data_byte,
    input  logic                               holds_byte,
    input  logic                               last,
    output logic                               job_push,
    output lbsh_pkg::job_t                     job,
    input  logic                               q_full
);
    import lbsh_pkg::*;

    logic [31:0]                 seed_reg, seed_next;
    logic                        norm_reg;
    logic [31:0]                 msg_seed_reg, msg_seed_next;
    logic [3:0]                  fill_reg, fill_next;
    logic [31:0]                 len_reg, len_next;
    logic [BLOCK_BYTES-1:0][7:0] buf_reg;

    logic       accept;
    logic       take;
    logic       blk_done;
    logic       seed_wr;
    logic [7:0] nb;
    logic [3:0] fill_inc;
    logic [BLOCK_BYTES-1:0][7:0] merged;

    assign full   = q_full;
    assign accept = push && !full;
    assign seed_wr = cfg_wr_en && (cfg_index == REG_SEED);
    assign seed_next = seed_wr ? cfg_data : seed_reg;

    always_comb
    begin
        nb = data_byte;
        if (norm_reg)
        begin
            if (data_byte >= 8'h61 && data_byte <= 8'h7A)
            begin
                nb = data_byte - 8'h20;
            end
            else if (data_byte == 8'h2F)
            begin
                nb = 8'h5C;
            end
        end
    end

    assign take     = accept && holds_byte && !(norm_reg && (len_reg >= MAX_NORM_BYTES));
    assign blk_done = take && (fill_reg == 4'(BLOCK_BYTES - 1));
    assign fill_inc = fill_reg + 4'(take);

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            merged[i] = (take && (fill_reg == 4'(i))) ? nb : buf_reg[i];
        end
    end

    always_comb
    begin
        job_push      = accept && (blk_done || last);
        job.has_block = blk_done;
        job.has_final = last;
        job.data      = merged;
        job.fill      = blk_done ? 4'd0 : fill_inc;
        job.len       = len_reg + 32'(take);
        job.seed      = msg_seed_reg;
    end

    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        if (accept)
        begin
            if (last)
            begin
                fill_next = 4'd0;
                len_next  = 32'd0;
            end
            else
            begin
                fill_next = blk_done ? 4'd0 : fill_inc;
                len_next  = len_reg + 32'(take);
            end
        end
        msg_seed_next = msg_seed_reg;
        if (accept && last)
        begin
            msg_seed_next = seed_next;
        end
        else if (seed_wr && (len_reg == 32'd0))
        begin
            msg_seed_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= 32'd0;
            norm_reg     <= 1'b1;
            msg_seed_reg <= 32'd0;
            fill_reg     <= 4'd0;
            len_reg      <= 32'd0;
        end
        else
        begin
            seed_reg     <= seed_next;
            msg_seed_reg <= msg_seed_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            if (cfg_wr_en && (cfg_index == REG_NORMALIZE))
            begin
                norm_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg[fill_reg] <= nb;
        end
    end

    `CHK_ALWAYS(a_fill_range, clk, rst_n, fill_reg < 4'(BLOCK_BYTES))

endmodule

FILE: rtl/lbsh_queue.sv
// Short job queue between the front end and the mix engine.
// Depends on lbsh_pkg.
`include "lookup2_byte_stream_hash_unit_macros.svh"
module lbsh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lbsh_pkg::job_t wr_job,
    output logic           q_full,
    input  logic           rd_en,
    output lbsh_pkg::job_t rd_job,
    output logic           q_empty
);
    import lbsh_pkg::*;

    localparam int PTR_W = $clog2(JOB_FIFO_DEPTH);
    localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

    job_t             q_reg [JOB_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(JOB_FIFO_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `CHK_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(JOB_FIFO_DEPTH))
    `CHK_IMPLY(a_no_write_full, clk, rst_n, wr_en, !q_full)
    `CHK_IMPLY(a_no_read_empty, clk, rst_n, rd_en, !q_empty)

endmodule

FILE: rtl/lbsh_back.sv
// Mix engine: block add, 9-step lookup2 mix one step per cycle, final and result word.
// Depends on lbsh_pkg.
`include "lookup2_byte_stream_hash_unit_macros.svh"
module lbsh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  lbsh_pkg::job_t head,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [31:0]    hash_value
);
    import lbsh_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'd8;

    function automatic mix_t mix_step(input logic [3:0] step, input mix_t w);
        mix_t r;
        r = w;
        case (step)
            4'd0: r.a = (w.c >> 13) ^ (w.a - w.b - w.c);
            4'd1: r.b = (w.a << 8)  ^ (w.b - w.c - w.a);
            4'd2: r.c = (w.b >> 13) ^ (w.c - w.a - w.b);
            4'd3: r.a = (w.c >> 12) ^ (w.a - w.b - w.c);
            4'd4: r.b = (w.a << 16) ^ (w.b - w.c - w.a);
            4'd5: r.c = (w.b >> 5)  ^ (w.c - w.a - w.b);
            4'd6: r.a = (w.c >> 3)  ^ (w.a - w.b - w.c);
            4'd7: r.b = (w.a << 10) ^ (w.b - w.c - w.a);
            4'd8: r.c = (w.b >> 15) ^ (w.c - w.a - w.b);
            default: r = w;
        endcase
        return r;
    endfunction

    bk_state_t   state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    mix_t        w_reg, w_next;
    mix_t        base;
    mix_t        stepped;
    logic        fresh_reg, fresh_next;
    logic        fin_pend_reg, fin_pend_next;
    logic        is_final_reg, is_final_next;
    logic [31:0] len_hold_reg, len_hold_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg, hash_next;
    logic        out_free;
    logic        out_we;
    logic [BLOCK_BYTES-1:0][7:0] tail;

    assign out_free   = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign hash_value = hash_reg;
    assign stepped    = mix_step(step_reg, w_reg);

    always_comb
    begin
        base = w_reg;
        if (fresh_reg)
        begin
            base.a = GOLDEN_WORD;
            base.b = GOLDEN_WORD;
            base.c = head.seed;
        end
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            tail[i] = ((4'(i) < head.fill) && (i < BLOCK_BYTES - 1)) ? head.data[i] : 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_MIX;
                end
            end
            BK_MIX:
            begin
                if (step_reg == LAST_STEP)
                begin
                    if (is_final_reg)
                    begin
                        if (out_free)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    else if (fin_pend_reg)
                    begin
                        state_next = BK_FIN;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_FIN:
            begin
                state_next = BK_MIX;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        out_we         = 1'b0;
        step_next      = step_reg;
        w_next         = w_reg;
        fresh_next     = fresh_reg;
        fin_pend_next  = fin_pend_reg;
        is_final_next  = is_final_reg;
        len_hold_next  = len_hold_reg;
        hash_next      = hash_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    fresh_next    = 1'b0;
                    step_next     = 4'd0;
                    len_hold_next = head.len;
                    fin_pend_next = head.has_final;
                    if (head.has_block)
                    begin
                        w_next.a      = base.a + {head.data[3], head.data[2],
                                                  head.data[1], head.data[0]};
                        w_next.b      = base.b + {head.data[7], head.data[6],
                                                  head.data[5], head.data[4]};
                        w_next.c      = base.c + {head.data[11], head.data[10],
                                                  head.data[9], head.data[8]};
                        is_final_next = 1'b0;
                    end
                    else
                    begin
                        w_next.a      = base.a + {tail[3], tail[2], tail[1], tail[0]};
                        w_next.b      = base.b + {tail[7], tail[6], tail[5], tail[4]};
                        w_next.c      = base.c + head.len
                                        + {tail[10], tail[9], tail[8], 8'h00};
                        is_final_next = 1'b1;
                    end
                end
            end
            BK_MIX:
            begin
                if (step_reg != LAST_STEP)
                begin
                    w_next    = stepped;
                    step_next = step_reg + 4'd1;
                end
                else if (is_final_reg)
                begin
                    if (out_free)
                    begin
                        out_we     = 1'b1;
                        hash_next  = stepped.c;
                        fresh_next = 1'b1;
                        step_next  = 4'd0;
                    end
                end
                else
                begin
                    w_next    = stepped;
                    step_next = 4'd0;
                end
            end
            BK_FIN:
            begin
                // message ended on a block boundary: no tail bytes
                w_next.c      = w_reg.c + len_hold_reg;
                is_final_next = 1'b1;
                fin_pend_next = 1'b0;
                step_next     = 4'd0;
            end
            default:
            begin
                step_next = 4'd0;
            end
        endcase
        out_valid_next = out_we ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= 4'd0;
            fresh_reg     <= 1'b1;
            fin_pend_reg  <= 1'b0;
            is_final_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fresh_reg     <= fresh_next;
            fin_pend_reg  <= fin_pend_next;
            is_final_reg  <= is_final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        len_hold_reg <= len_hold_next;
        hash_reg     <= hash_next;
    end

    `CHK_ALWAYS(a_step_range, clk, rst_n, step_reg <= LAST_STEP)
    `CHK_IMPLY(a_out_slot_free, clk, rst_n, out_we, out_valid_reg == 1'b0 || pop)

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for lookup2_byte_stream_hash_unit: byte words in, hashes out,
// each hash compared with an in-bench lookup2 model. Depends on lbsh_pkg and the RTL.
module tb_top;
    import lbsh_pkg::*;

    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CASE_GAP       = 8'h20;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 50;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   push;
    logic                   full;
    logic [7:0]             data_byte;
    logic                   holds_byte;
    logic                   last;
    logic                   empty;
    logic                   pop;
    logic [31:0]            hash_value;

    logic [31:0] seed_reg;
    logic        norm_reg;
    logic [31:0] acc_a;
    logic [31:0] acc_b;
    logic [31:0] acc_c;
    logic [7:0]  blk_bytes [BLOCK_BYTES];
    int unsigned blk_fill;
    logic [31:0] msg_len;

    logic [31:0] expected_hashes [$];
    logic [31:0] rx_want;
    int err_count;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int stall_left;

    lookup2_byte_stream_hash_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .holds_byte (holds_byte),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic mix_t lookup2_mix(mix_t m);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = m.a;
        b = m.b;
        c = m.c;
        a = (c >> 13) ^ (a - b - c);
        b = (a << 8) ^ (b - c - a);
        c = (b >> 13) ^ (c - a - b);
        a = (c >> 12) ^ (a - b - c);
        b = (a << 16) ^ (b - c - a);
        c = (b >> 5) ^ (c - a - b);
        a = (c >> 3) ^ (a - b - c);
        b = (a << 10) ^ (b - c - a);
        c = (b >> 15) ^ (c - a - b);
        return {a, b, c};
    endfunction

    function automatic void begin_message();
        acc_a    = GOLDEN_WORD;
        acc_b    = GOLDEN_WORD;
        acc_c    = seed_reg;
        blk_fill = 0;
        msg_len  = '0;
    endfunction

    function automatic void absorb_byte(logic [7:0] value);
        logic [7:0] v;
        mix_t       m;
        v = value;
        if (norm_reg)
        begin
            if (msg_len >= MAX_NORM_BYTES)
                return;
            if (v >= CHAR_LOWER_A && v <= CHAR_LOWER_Z)
                v = v - CASE_GAP;
            else if (v == CHAR_SLASH)
                v = CHAR_BACKSLASH;
        end
        blk_bytes[blk_fill] = v;
        blk_fill++;
        msg_len++;
        if (blk_fill == BLOCK_BYTES)
        begin
            m.a = acc_a + {blk_bytes[3], blk_bytes[2], blk_bytes[1], blk_bytes[0]};
            m.b = acc_b + {blk_bytes[7], blk_bytes[6], blk_bytes[5], blk_bytes[4]};
            m.c = acc_c + {blk_bytes[11], blk_bytes[10], blk_bytes[9], blk_bytes[8]};
            m = lookup2_mix(m);
            acc_a = m.a;
            acc_b = m.b;
            acc_c = m.c;
            blk_fill = 0;
        end
    endfunction

    function automatic logic [31:0] close_message();
        mix_t        m;
        logic [31:0] v;
        int          i;
        m.a = acc_a;
        m.b = acc_b;
        m.c = acc_c + msg_len;
        for (i = 0; i < blk_fill && i < BLOCK_BYTES - 1; i++)
        begin
            v = {24'h0, blk_bytes[i]};
            if (i < 4)
                m.a += v << (8 * i);
            else if (i < 8)
                m.b += v << (8 * (i - 4));
            else
                m.c += v << (8 * (i - 7));
        end
        m = lookup2_mix(m);
        return m.c;
    endfunction

    function automatic void hash_model_step(logic [7:0] value, logic holds, logic is_last);
        if (holds)
            absorb_byte(value);
        if (is_last)
        begin
            expected_hashes.push_back(close_message());
            begin_message();
        end
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(CHAR_LOWER_Z, CHAR_LOWER_A));
            1:       return ($urandom_range(1) == 0) ? CHAR_SLASH : CHAR_BACKSLASH;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_hashes.size() == 0)
                    report_mismatch("unexpected hash word", hash_value, 32'h0);
                else
                begin
                    rx_want = expected_hashes.pop_front();
                    if (hash_value !== rx_want)
                        report_mismatch("hash_value", hash_value, rx_want);
                end
            end
            if (stall_request != 0)
            begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(logic [7:0] value, logic holds, logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= value;
        holds_byte <= holds;
        last       <= is_last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        hash_model_step(value, holds, is_last);
        if (holds || is_last)
            items_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_SEED)
        begin
            seed_reg = value;
            if (msg_len == 0)
                acc_c = seed_reg;
        end
        else if (idx == REG_NORMALIZE)
            norm_reg = value[0];
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_message();
        int   len;
        int   i;
        logic tail_last;
        len = ($urandom_range(7) == 0) ? $urandom_range(60, 26) : $urandom_range(25);
        tail_last = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(random_byte(), 1'b1, tail_last && (i == len - 1));
        end
        if (!tail_last)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        int i;
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(CHAR_LOWER_A, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(CHAR_SLASH, 1'b1, 1'b0);
        send_word(CHAR_LOWER_Z, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        for (i = 0; i < BLOCK_BYTES; i++)
            send_word(8'hFF - 8'(i), 1'b1, i == BLOCK_BYTES - 1);
        wait_idle();
        write_reg(REG_NORMALIZE, 32'h0);
        send_word(CHAR_LOWER_A, 1'b1, 1'b0);
        send_word(CHAR_SLASH, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_mid_message();
        int i;
        write_reg(REG_NORMALIZE, 32'h1);
        send_word(8'h00, 1'b0, 1'b0);
        wait_idle();
        // no byte taken yet: new seed applies to this message
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        for (i = 0; i < 3; i++)
            send_word(random_byte(), 1'b1, 1'b0);
        wait_idle();
        // bytes pending: seed waits for next message, mode applies now
        write_reg(REG_SEED, $urandom());
        write_reg(REG_NORMALIZE, 32'h0);
        send_word(CHAR_LOWER_Z, 1'b1, 1'b0);
        send_word(CHAR_SLASH, 1'b1, 1'b1);
        send_word(CHAR_LOWER_A, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_truncation();
        int i;
        write_reg(REG_NORMALIZE, 32'h1);
        write_reg(REG_SEED, $urandom());
        for (i = 0; i < MAX_NORM_BYTES + 3; i++)
            send_word(random_byte(), 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_NORMALIZE, 32'h0);
        for (i = 0; i < 3; i++)
            send_word(random_byte(), 1'b1, i == 2);
        wait_idle();
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, logic [31:0] seed, logic norm);
        int first;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(REG_SEED, seed);
        write_reg(REG_NORMALIZE, {31'h0, norm});
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS)
            send_random_message();
        wait_idle();
    endtask

    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 500;
        for (i = 0; i < 40; i++)
            send_word(random_byte(), 1'b1, 1'b1);
        wait_idle();
        for (i = 0; i < 4; i++)
            send_random_message();
        wait_idle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        push          = 1'b0;
        data_byte     = '0;
        holds_byte    = 1'b0;
        last          = 1'b0;
        pop           = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        stall_request = 0;
        stall_left    = 0;
        send_idle_pct = 34;
        recv_idle_pct = 52;
        seed_reg      = '0;
        norm_reg      = 1'b1;
        begin_message();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_mid_message();
        test_truncation();
        test_random_phase(34, 52, 32'h0000_0000, 1'b0);
        test_random_phase(52, 34, 32'hFFFF_FFFF, 1'b1);
        test_random_phase(0, 0, $urandom(), 1'($urandom_range(1)));
        test_backpressure();

        wait_idle();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
